### hw/rtl/wms_pkg.sv
// wms_pkg: constants, codes and controller/datapath bundles for the
// window minimizer select block. No dependencies.
`default_nettype none

package wms_pkg;

	localparam int MAX_KMERS = 64;
	localparam int RANK_BITS = 16;

	localparam int RANK_IN_W = 16;
	localparam int WIN_W     = 7;
	localparam int POS_W     = 6;
	localparam int ST_W      = 2;
	localparam int CNT_W     = $clog2(MAX_KMERS + 1);
	localparam int ADDR_W    = $clog2(MAX_KMERS);
	localparam int SUM_W     = ((CNT_W > WIN_W) ? CNT_W : WIN_W) + 1;

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(8);

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 2'd0,
		ST_UNKNOWN  = 2'd1,
		ST_FEW      = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OUT_STATUS = 2'd0,
		OUT_PEND   = 2'd1,
		OUT_FINAL  = 2'd2
	} out_kind_t;

	typedef struct packed {
		logic      load;
		logic      clear_seq;
		logic      scan_init;
		logic      issue;
		logic      win_next;
		logic      take_best;
		logic      push;
		out_kind_t kind;
	} cmd_t;

	typedef struct packed {
		status_t st;
		logic    issue_last;
		logic    last_window;
		logic    best_new;
		logic    pend_valid;
		logic    out_free;
	} sts_t;

endpackage

`default_nettype wire

### hw/rtl/wms_if.sv
// Request channels of the window minimizer select block: k-mer input and
// minimizer result. Depends on wms_pkg.
`default_nettype none

interface wms_in_if
	import wms_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [RANK_IN_W-1:0] kmer_rank;
	logic                 kmer_known;
	logic                 last_kmer;

	modport source (output valid, kmer_rank, kmer_known, last_kmer, input ready);
	modport sink   (input valid, kmer_rank, kmer_known, last_kmer, output ready);
endinterface

interface wms_out_if
	import wms_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] min_position;
	logic [ST_W-1:0]  status;
	logic             no_position;
	logic             last_result;

	modport source (output valid, min_position, status, no_position, last_result,
		input ready);
	modport sink   (input valid, min_position, status, no_position, last_result,
		output ready);
endinterface

`default_nettype wire

### hw/rtl/wms_ram.sv
// wms_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module wms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/wms_dp.sv
// wms_dp: datapath - sequence counters, rank store, window scan, pending
// result and output register. Depends on wms_pkg and wms_ram.
`default_nettype none

module wms_dp
	import wms_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [WIN_W-1:0]     cfg_wdata,
	input  wire logic [RANK_IN_W-1:0] kmer_rank,
	input  wire logic                 kmer_known,
	input  wire cmd_t                 cmd,
	output sts_t                      sts,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output logic      [POS_W-1:0]     min_position,
	output logic      [ST_W-1:0]      status,
	output logic                      no_position,
	output logic                      last_result
);

	logic [WIN_W-1:0]     window_q;
	logic [CNT_W-1:0]     count_q;
	logic                 unknown_q;
	logic                 overflow_q;
	logic [CNT_W-1:0]     start_q;
	logic [CNT_W-1:0]     idx_q;
	logic                 rd_valid_s1;
	logic [CNT_W-1:0]     rd_pos_s1;
	logic [RANK_BITS-1:0] best_rank_q;
	logic [CNT_W-1:0]     best_pos_q;
	logic                 pend_valid_q;
	logic [CNT_W-1:0]     pend_pos_q;
	logic                 out_valid_q;
	logic [POS_W-1:0]     out_pos_q;
	logic [ST_W-1:0]      out_st_q;
	logic                 out_nopos_q;
	logic                 out_last_q;

	logic [WIN_W-1:0]     win;
	logic [SUM_W-1:0]     win_ext;
	logic                 has_room;
	logic                 store_we;
	logic [RANK_BITS-1:0] rd_rank;
	logic                 take_read;
	status_t              seq_st;

	// zero window behaves as one
	assign win     = (window_q == '0) ? WIN_W'(1) : window_q;
	assign win_ext = SUM_W'(win);

	assign has_room = (count_q < CNT_W'(MAX_KMERS));
	assign store_we = cmd.load && has_room;

	wms_ram #(
		.WIDTH(RANK_BITS),
		.DEPTH(MAX_KMERS)
	) u_rank_ram (
		.clk  (clk),
		.we   (store_we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(RANK_BITS'(kmer_rank)),
		.raddr(idx_q[ADDR_W-1:0]),
		.rdata(rd_rank)
	);

	always_comb begin
		if (overflow_q) begin
			seq_st = ST_OVERFLOW;
		end else if (unknown_q) begin
			seq_st = ST_UNKNOWN;
		end else if (SUM_W'(count_q) < win_ext) begin
			seq_st = ST_FEW;
		end else begin
			seq_st = ST_OK;
		end
	end

	assign take_read = rd_valid_s1 && ((rd_pos_s1 == start_q) || (rd_rank < best_rank_q));

	assign sts.st          = seq_st;
	assign sts.issue_last  = (SUM_W'(idx_q) + SUM_W'(1)) == (SUM_W'(start_q) + win_ext);
	assign sts.last_window = (SUM_W'(start_q) + win_ext) == SUM_W'(count_q);
	assign sts.best_new    = !pend_valid_q || (best_pos_q != pend_pos_q);
	assign sts.pend_valid  = pend_valid_q;
	assign sts.out_free    = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= WIN_RESET;
			count_q      <= '0;
			unknown_q    <= 1'b0;
			overflow_q   <= 1'b0;
			rd_valid_s1  <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			if (cmd.clear_seq) begin
				count_q    <= '0;
				unknown_q  <= 1'b0;
				overflow_q <= 1'b0;
			end else if (cmd.load) begin
				if (has_room) begin
					count_q <= count_q + CNT_W'(1);
					if (!kmer_known) begin
						unknown_q <= 1'b1;
					end
				end else begin
					overflow_q <= 1'b1;
				end
			end
			rd_valid_s1 <= cmd.issue;
			if (cmd.scan_init) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.take_best) begin
				pend_valid_q <= 1'b1;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			start_q <= '0;
			idx_q   <= '0;
		end else if (cmd.win_next) begin
			start_q <= start_q + CNT_W'(1);
			idx_q   <= start_q + CNT_W'(1);
		end else if (cmd.issue) begin
			idx_q <= idx_q + CNT_W'(1);
		end
		rd_pos_s1 <= idx_q;
		if (take_read) begin
			best_rank_q <= rd_rank;
			best_pos_q  <= rd_pos_s1;
		end
		if (cmd.take_best) begin
			pend_pos_q <= best_pos_q;
		end
		if (cmd.push) begin
			case (cmd.kind)
				OUT_PEND: begin
					out_pos_q   <= POS_W'(pend_pos_q);
					out_st_q    <= ST_OK;
					out_nopos_q <= 1'b0;
					out_last_q  <= 1'b0;
				end
				OUT_FINAL: begin
					out_pos_q   <= POS_W'(pend_pos_q);
					out_st_q    <= ST_OK;
					out_nopos_q <= 1'b0;
					out_last_q  <= 1'b1;
				end
				default: begin
					out_pos_q   <= '0;
					out_st_q    <= seq_st;
					out_nopos_q <= 1'b1;
					out_last_q  <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign min_position = out_pos_q;
	assign status       = out_st_q;
	assign no_position  = out_nopos_q;
	assign last_result  = out_last_q;

endmodule

`default_nettype wire

### hw/rtl/wms_ctrl.sv
// wms_ctrl: sequencer for load, status check, window scan and result push.
// Depends on wms_pkg.
`default_nettype none

module wms_ctrl
	import wms_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic last_kmer,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [6:0] {
		S_LOAD   = 7'b0000001,
		S_CHECK  = 7'b0000010,
		S_STAT   = 7'b0000100,
		S_SCAN   = 7'b0001000,
		S_WAIT   = 7'b0010000,
		S_DECIDE = 7'b0100000,
		S_FINAL  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.kind = OUT_STATUS;
		in_ready = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last_kmer) begin
						state_d = S_CHECK;
					end
				end
			end
			S_CHECK: begin
				if (sts.st != ST_OK) begin
					state_d = S_STAT;
				end else begin
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_STAT: begin
				if (sts.out_free) begin
					cmd.push      = 1'b1;
					cmd.kind      = OUT_STATUS;
					cmd.clear_seq = 1'b1;
					state_d       = S_LOAD;
				end
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.issue_last) begin
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				// a new position displaces the pending one, which then needs a slot
				if (!(sts.best_new && sts.pend_valid && !sts.out_free)) begin
					if (sts.best_new) begin
						cmd.take_best = 1'b1;
						if (sts.pend_valid) begin
							cmd.push = 1'b1;
							cmd.kind = OUT_PEND;
						end
					end
					if (sts.last_window) begin
						state_d = S_FINAL;
					end else begin
						cmd.win_next = 1'b1;
						state_d      = S_SCAN;
					end
				end
			end
			S_FINAL: begin
				if (sts.out_free) begin
					cmd.push      = 1'b1;
					cmd.kind      = OUT_FINAL;
					cmd.clear_seq = 1'b1;
					state_d       = S_LOAD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/window_minimizer_select.sv
// window_minimizer_select: top level, joins the sequencer and the datapath.
// Depends on wms_pkg, wms_if, wms_ctrl, wms_dp (and through it wms_ram).
//
//  channel     dir  handshake       payload
//  kmers       in   valid/ready     kmer_rank[15:0], kmer_known, last_kmer
//  minimizers  out  valid/ready     min_position[5:0], status[1:0],
//                                   no_position, last_result
//  cfg         in   cfg_we only     cfg_wdata[6:0] -> window_kmers
//
// Loading: one k-mer request per cycle, kmers.ready high while loading.
// After the last k-mer comes a check state; then for a good sequence each of
// the (count - window + 1) windows is read rank by rank, bound by the single
// read port of the rank RAM (one stored rank per cycle), then decided after a
// wait step; a bad sequence gives one status request after the check state.
// Reset clears the k-mer count, flags and handshake state and loads the reset
// window of 8; the RAM needs no clearing pass, as only current entries are read.
// A stalled result output holds the scan in its decision step; the held result
// sits in the output register.
`default_nettype none

module window_minimizer_select
	import wms_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [WIN_W-1:0] cfg_wdata,
	wms_in_if.sink                kmers,
	wms_out_if.source             minimizers
);

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	assign kmers.ready = in_ready;

	wms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (kmers.valid),
		.last_kmer(kmers.last_kmer),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wms_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.kmer_rank   (kmers.kmer_rank),
		.kmer_known  (kmers.kmer_known),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (minimizers.ready),
		.out_valid   (minimizers.valid),
		.min_position(minimizers.min_position),
		.status      (minimizers.status),
		.no_position (minimizers.no_position),
		.last_result (minimizers.last_result)
	);

endmodule

`default_nettype wire

### hw/rtl/wms_checker.sv
// wms_checker: port-level checks on the window minimizer select block, bound
// to the top level. Depends on wms_pkg and window_minimizer_select.
`default_nettype none

module wms_checker
	import wms_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             in_last,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [POS_W-1:0] out_pos,
	input wire logic [ST_W-1:0]  out_status,
	input wire logic             out_nopos,
	input wire logic             out_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pos) && $stable(out_status))
		else $error("result dropped or changed while stalled");

	a_nopos_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_nopos == (out_status != ST_OK)))
		else $error("no_position does not match status");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_nopos |-> out_last && (out_pos == '0))
		else $error("status result not final or carries a position");

	a_stop_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input taken straight after the last k-mer");

endmodule

bind window_minimizer_select wms_checker u_wms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (kmers.valid),
	.in_ready  (kmers.ready),
	.in_last   (kmers.last_kmer),
	.out_valid (minimizers.valid),
	.out_ready (minimizers.ready),
	.out_pos   (minimizers.min_position),
	.out_status(minimizers.status),
	.out_nopos (minimizers.no_position),
	.out_last  (minimizers.last_result)
);

`default_nettype wire

### test/wms_tb_pkg.sv
// Scoreboard for the window minimizer select testbench: predicts minimizer
// requests from accepted k-mers and checks them in order. Depends on wms_pkg.
package wms_tb_pkg;
	import wms_pkg::*;

	typedef struct {
		logic [POS_W-1:0] pos;
		status_t          st;
		logic             no_pos;
		logic             last;
	} minimizer_t;

	class minimizer_scoreboard;
		logic [RANK_BITS-1:0] ranks [MAX_KMERS];
		int unsigned          count;
		bit                   unknown_seen;
		bit                   overflow_seen;
		int unsigned          prev_pos;
		logic [WIN_W-1:0]     window;
		minimizer_t           expected_q [$];
		int unsigned          errors;

		function new();
			window = WIN_RESET;
			errors = 0;
			clear_seq();
		endfunction

		function void clear_seq();
			count         = 0;
			unknown_seen  = 1'b0;
			overflow_seen = 1'b0;
			prev_pos      = 127;
		endfunction

		function void set_window(logic [WIN_W-1:0] w);
			window = w;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// appends one predicted request at the tail
		function void queue_expected(minimizer_t r);
			expected_q.insert(expected_q.size(), r);
		endfunction

		// called on every accepted k-mer request
		function void note_kmer(logic [RANK_IN_W-1:0] rank, logic known, logic last);
			int unsigned win;
			int unsigned best;
			minimizer_t  r;
			if (count < MAX_KMERS) begin
				ranks[count] = rank[RANK_BITS-1:0];
				count++;
				if (!known)
					unknown_seen = 1'b1;
			end else begin
				overflow_seen = 1'b1;
			end
			if (!last)
				return;
			win      = (window == 0) ? 1 : window;
			r.pos    = '0;
			r.no_pos = 1'b1;
			r.last   = 1'b1;
			if (overflow_seen)
				r.st = ST_OVERFLOW;
			else if (unknown_seen)
				r.st = ST_UNKNOWN;
			else if (count < win)
				r.st = ST_FEW;
			else
				r.st = ST_OK;
			if (r.st != ST_OK) begin
				queue_expected(r);
			end else begin
				r.no_pos = 1'b0;
				r.last   = 1'b0;
				for (int unsigned s = 0; s + win <= count; s++) begin
					best = s;
					for (int unsigned j = s + 1; j < s + win; j++)
						if (ranks[j] < ranks[best])
							best = j;
					if (best != prev_pos) begin
						r.pos = best[POS_W-1:0];
						queue_expected(r);
						prev_pos = best;
					end
				end
				expected_q[expected_q.size() - 1].last = 1'b1;
			end
			clear_seq();
		endfunction

		function void check_result(minimizer_t got);
			minimizer_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected minimizer request pos %0d status %0d no_pos %b last %b",
					$time, got.pos, got.st, got.no_pos, got.last);
				return;
			end
			want = expected_q.pop_front();
			if (got.pos !== want.pos || got.st !== want.st ||
					got.no_pos !== want.no_pos || got.last !== want.last) begin
				errors++;
				$display("%0t: minimizer mismatch, expected pos %0d status %0d no_pos %b last %b",
					$time, want.pos, want.st, want.no_pos, want.last);
				$display("%0t:                      actual pos %0d status %0d no_pos %b last %b",
					$time, got.pos, got.st, got.no_pos, got.last);
			end
		endfunction
	endclass

endpackage

### test/tb_top.sv
// tb_top: drives k-mer sequences into window_minimizer_select and checks the
// minimizer requests against a scoreboard. Depends on wms_pkg, wms_if, wms_tb_pkg.
module tb_top;
	import wms_pkg::*;
	import wms_tb_pkg::*;

	// drain margin for two windows of the largest size still in flight, plus slack
	localparam int unsigned SETTLE_CYCLES = 2 * (MAX_KMERS + 2) + 16;
	localparam int unsigned PHASE_ITEMS   = 10;
	localparam int unsigned SHORT_MAX     = 20;
	localparam int unsigned HOLD_CYCLES   = 400;

	// window settings, one per random phase; 0 and 127 are the field extremes,
	// 65 and 127 can never be filled so every sequence there is too short
	localparam logic [WIN_W-1:0] WINDOW_PLAN [10] = '{
		7'd1, 7'd64, 7'd0, 7'd3, 7'd127, 7'd5, 7'd2, 7'd16, 7'd33, 7'd65
	};

	// tie-heavy directed sequence for the reset window of 8: the low rank at
	// position 1 wins over its tie at 2, and the second window repeats it
	localparam logic [RANK_IN_W-1:0] TIE_RANKS [9] = '{
		16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0007, 16'h0007, 16'h0003,
		16'hFFFF, 16'h0000
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [WIN_W-1:0] cfg_wdata;

	wms_in_if  kmer_bus ();
	wms_out_if result_bus ();

	window_minimizer_select uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.kmers      (kmer_bus),
		.minimizers (result_bus)
	);

	minimizer_scoreboard sb;

	bit calm;      // no idling on either side while set
	bit hold_req;  // asks the receiver for one long hold-off

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// run limit, far above the slowest correct run
	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic bit take_break();
		return !calm && ($urandom_range(0, 99) < 7);
	endfunction

	// one k-mer request: payload set at the falling edge, accepted at the
	// first rising edge with ready high; valid stays up for the next call
	task automatic send_kmer(logic [RANK_IN_W-1:0] rank, logic known, logic last);
		@(negedge clk);
		while (take_break()) begin
			kmer_bus.valid <= 1'b0;
			@(negedge clk);
		end
		kmer_bus.valid      <= 1'b1;
		kmer_bus.kmer_rank  <= rank;
		kmer_bus.kmer_known <= known;
		kmer_bus.last_kmer  <= last;
		do @(posedge clk); while (!kmer_bus.ready);
		sb.note_kmer(rank, known, last);
	endtask

	task automatic send_sequence(int unsigned len, bit with_unknown, bit tie_heavy);
		int unsigned          bad_at;
		logic [RANK_IN_W-1:0] rank;
		bad_at = $urandom_range(0, len - 1);
		for (int unsigned i = 0; i < len; i++) begin
			rank = tie_heavy ? RANK_IN_W'($urandom_range(0, 3))
				: RANK_IN_W'($urandom_range(0, 65535));
			send_kmer(rank, !(with_unknown && i == bad_at), i == len - 1);
		end
	endtask

	// register write only once the block has drained and gone quiet
	task automatic set_window(logic [WIN_W-1:0] w);
		@(negedge clk);
		kmer_bus.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_window(w);
	endtask

	// receiver: ready changes at the falling edge; a hold-off request keeps it
	// low for a long count so the block backs up into its k-mer input
	initial begin
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			result_bus.ready <= calm || ($urandom_range(0, 99) >= 7);
		end
	end

	// monitor: every accepted minimizer request goes to the scoreboard
	initial begin
		minimizer_t got;
		forever begin
			@(posedge clk);
			if (arst_n && result_bus.valid && result_bus.ready) begin
				got.pos    = result_bus.min_position;
				got.st     = status_t'(result_bus.status);
				got.no_pos = result_bus.no_position;
				got.last   = result_bus.last_result;
				sb.check_result(got);
			end
		end
	end

	initial begin
		int unsigned phase_items;
		int unsigned len;
		int unsigned eff;
		int unsigned roll;

		sb                  = new();
		calm                = 1'b0;
		hold_req            = 1'b0;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		kmer_bus.valid      = 1'b0;
		kmer_bus.kmer_rank  = '0;
		kmer_bus.kmer_known = 1'b0;
		kmer_bus.last_kmer  = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part, reset window of 8
		foreach (TIE_RANKS[i])
			send_kmer(TIE_RANKS[i], 1'b1, i == 8);
		send_kmer(16'hFFFF, 1'b0, 1'b1);          // lone unknown k-mer beats too few
		send_kmer(16'h0000, 1'b1, 1'b0);          // three k-mers: too few
		send_kmer(16'hFFFF, 1'b1, 1'b0);
		send_kmer(16'h8000, 1'b1, 1'b1);
		for (int unsigned i = 0; i < 8; i++)      // unknown in the middle of a full window
			send_kmer(16'h5555 << i[0], i != 4, i == 7);

		// random phases, one window setting each
		foreach (WINDOW_PLAN[p]) begin
			set_window(WINDOW_PLAN[p]);
			calm        = (WINDOW_PLAN[p] == 3);
			eff         = (WINDOW_PLAN[p] == 0) ? 1 : WINDOW_PLAN[p];
			phase_items = 0;
			if (WINDOW_PLAN[p] == 5) begin
				// overflow: the requests beyond MAX_KMERS, the last among them, are dropped;
				// the result side holds off meanwhile so the input backs up
				hold_req = 1'b1;
				len      = MAX_KMERS + $urandom_range(1, 4);
				send_sequence(len, 1'b1, 1'b0);
				phase_items += len;
			end
			while (phase_items < PHASE_ITEMS) begin
				roll = $urandom_range(0, 99);
				if (eff > MAX_KMERS)
					len = $urandom_range(1, SHORT_MAX);
				else if (roll < 10 && eff > 1)
					len = $urandom_range(1, eff - 1);
				else
					len = eff + $urandom_range(0, 10);
				if (len > MAX_KMERS)
					len = MAX_KMERS;
				send_sequence(len, roll >= 10 && roll < 20, $urandom_range(0, 99) < 30);
				phase_items += len;
			end
		end

		@(negedge clk);
		kmer_bus.valid <= 1'b0;
		calm = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
